/* rtl/core/ptlsc_pkg.sv */
// ----------------------------------------------------------------------------
// ptlsc_pkg
// Shared types and codes for the pan/tilt limit scan controller.
// ----------------------------------------------------------------------------
package ptlsc_pkg;

  // Register file
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;

  localparam logic [AddrWidth-1:0] ADDR_PAN_SPEED    = 4'h0;
  localparam logic [AddrWidth-1:0] ADDR_TILT_SPEED   = 4'h4;
  localparam logic [AddrWidth-1:0] ADDR_CENTER_STEPS = 4'h8;

  localparam logic [7:0] PAN_SPEED_RESET    = 8'd1;
  localparam logic [7:0] TILT_SPEED_RESET   = 8'd8;
  localparam logic [7:0] CENTER_STEPS_RESET = 8'd40;

  // Run modes
  localparam logic [2:0] MODE_STOP      = 3'd0;
  localparam logic [2:0] MODE_MANUAL    = 3'd1;
  localparam logic [2:0] MODE_PAN_SCAN  = 3'd2;
  localparam logic [2:0] MODE_TILT_SCAN = 3'd3;
  localparam logic [2:0] MODE_HOME_PAN  = 3'd4;
  localparam logic [2:0] MODE_HOME_TILT = 3'd5;
  localparam logic [2:0] MODE_CENTER    = 3'd6;

  // Commands
  localparam logic [2:0] CMD_HALT      = 3'd0;
  localparam logic [2:0] CMD_PAN_FWD   = 3'd1;
  localparam logic [2:0] CMD_PAN_REV   = 3'd2;
  localparam logic [2:0] CMD_TILT_FWD  = 3'd3;
  localparam logic [2:0] CMD_TILT_REV  = 3'd4;
  localparam logic [2:0] CMD_PAN_SCAN  = 3'd5;
  localparam logic [2:0] CMD_TILT_SCAN = 3'd6;

  // Item kinds
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  // Axes and directions
  localparam logic AXIS_PAN  = 1'b0;
  localparam logic AXIS_TILT = 1'b1;
  localparam logic DIR_FWD   = 1'b0;
  localparam logic DIR_REV   = 1'b1;

  // Limit switch bit positions
  localparam int unsigned LIM_PAN_FWD  = 0;
  localparam int unsigned LIM_PAN_REV  = 1;
  localparam int unsigned LIM_TILT_REV = 2;
  localparam int unsigned LIM_TILT_FWD = 3;

  typedef struct packed {
    logic       func;
    logic [2:0] cmd;
    logic [3:0] limit_status;
  } item_t;

  typedef struct packed {
    logic       step_enable;
    logic       axis;
    logic       direction;
    logic [7:0] speed;
    logic [2:0] mode;
  } result_t;

  typedef struct packed {
    logic [7:0] pan_speed;
    logic [7:0] tilt_speed;
    logic [7:0] center_steps;
  } cfg_t;

endpackage

/* rtl/core/ptlsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ptlsc_cfg_regs
// APB-style register file: pan speed, tilt speed and centering step count.
// ----------------------------------------------------------------------------
module ptlsc_cfg_regs
  import ptlsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_speed    <= PAN_SPEED_RESET;
      cfg.tilt_speed   <= TILT_SPEED_RESET;
      cfg.center_steps <= CENTER_STEPS_RESET;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_PAN_SPEED:    cfg.pan_speed    <= pwdata[7:0];
        ADDR_TILT_SPEED:   cfg.tilt_speed   <= pwdata[7:0];
        ADDR_CENTER_STEPS: cfg.center_steps <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_PAN_SPEED:    prdata[7:0] = cfg.pan_speed;
      ADDR_TILT_SPEED:   prdata[7:0] = cfg.tilt_speed;
      ADDR_CENTER_STEPS: prdata[7:0] = cfg.center_steps;
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/core/ptlsc_motion.sv */
// ----------------------------------------------------------------------------
// ptlsc_motion
// Motion state (mode, axis, direction, centering count) and the per-item
// decision logic that produces one step result.
// ----------------------------------------------------------------------------
module ptlsc_motion
  import ptlsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [2:0] run_mode, run_mode_next;
  logic       move_axis, move_axis_next;
  logic       move_direction, move_direction_next;
  logic [7:0] center_count, center_count_next;

  logic       step;
  logic       fwd_hit, rev_hit;
  logic       dir_bounced, turned;
  logic [7:0] center_dec;

  // Limit bits for the current axis
  assign fwd_hit = (move_axis == AXIS_TILT) ? item.limit_status[LIM_TILT_FWD]
                                            : item.limit_status[LIM_PAN_FWD];
  assign rev_hit = (move_axis == AXIS_TILT) ? item.limit_status[LIM_TILT_REV]
                                            : item.limit_status[LIM_PAN_REV];

  // Bounce: forward limit flips to reverse, then reverse limit flips back
  always_comb begin
    dir_bounced = move_direction;
    if (move_direction == DIR_FWD && fwd_hit) dir_bounced = DIR_REV;
    turned = (dir_bounced == DIR_REV) && rev_hit;
    if (turned) dir_bounced = DIR_FWD;
  end

  assign center_dec = center_count - 8'd1;

  // Next-state decision
  always_comb begin
    run_mode_next       = run_mode;
    move_axis_next      = move_axis;
    move_direction_next = move_direction;
    center_count_next   = center_count;
    step                = 1'b0;

    if (item.func == FUNC_COMMAND) begin
      unique case (item.cmd)
        CMD_HALT: run_mode_next = MODE_STOP;
        CMD_PAN_FWD: begin
          run_mode_next = MODE_MANUAL; move_axis_next = AXIS_PAN;
          move_direction_next = DIR_FWD;
        end
        CMD_PAN_REV: begin
          run_mode_next = MODE_MANUAL; move_axis_next = AXIS_PAN;
          move_direction_next = DIR_REV;
        end
        CMD_TILT_FWD: begin
          run_mode_next = MODE_MANUAL; move_axis_next = AXIS_TILT;
          move_direction_next = DIR_FWD;
        end
        CMD_TILT_REV: begin
          run_mode_next = MODE_MANUAL; move_axis_next = AXIS_TILT;
          move_direction_next = DIR_REV;
        end
        CMD_PAN_SCAN: begin
          run_mode_next = MODE_PAN_SCAN; move_axis_next = AXIS_PAN;
          move_direction_next = DIR_FWD;
        end
        CMD_TILT_SCAN: begin
          run_mode_next = MODE_TILT_SCAN; move_axis_next = AXIS_TILT;
          move_direction_next = DIR_FWD;
        end
        default: ;  // unknown command: no change
      endcase
    end else begin
      unique case (run_mode)
        MODE_STOP: ;
        MODE_MANUAL: begin
          // stop without stepping at the limit we are heading into
          if ((move_direction == DIR_REV) ? rev_hit : fwd_hit) begin
            run_mode_next = MODE_STOP;
          end else begin
            step = 1'b1;
          end
        end
        MODE_PAN_SCAN, MODE_TILT_SCAN: begin
          move_direction_next = dir_bounced;
          step                = 1'b1;
        end
        MODE_HOME_PAN: begin
          move_direction_next = dir_bounced;
          if (turned) begin
            run_mode_next       = MODE_HOME_TILT;
            move_axis_next      = AXIS_TILT;
            move_direction_next = DIR_FWD;
          end else begin
            step = 1'b1;
          end
        end
        MODE_HOME_TILT: begin
          move_direction_next = dir_bounced;
          if (turned) begin
            run_mode_next       = (cfg.center_steps == 8'd0) ? MODE_STOP : MODE_CENTER;
            move_axis_next      = AXIS_TILT;
            move_direction_next = DIR_FWD;
            center_count_next   = cfg.center_steps;
          end else begin
            step = 1'b1;
          end
        end
        MODE_CENTER: begin
          if (center_count == 8'd0) begin
            run_mode_next = MODE_STOP;
          end else begin
            step              = 1'b1;
            center_count_next = center_dec;
            if (center_dec == 8'd0) run_mode_next = MODE_STOP;
          end
        end
        default: run_mode_next = MODE_STOP;
      endcase
    end
  end

  // Result for this item
  always_comb begin
    result.step_enable = step;
    result.axis        = move_axis_next;
    result.direction   = move_direction_next;
    result.speed       = step ? ((move_axis_next == AXIS_TILT) ? cfg.tilt_speed
                                                                : cfg.pan_speed)
                              : 8'd0;
    result.mode        = run_mode_next;
  end

  // State registers, updated as each item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= MODE_HOME_PAN;
      move_axis      <= AXIS_PAN;
      move_direction <= DIR_FWD;
      center_count   <= CENTER_STEPS_RESET;
    end else if (advance) begin
      run_mode       <= run_mode_next;
      move_axis      <= move_axis_next;
      move_direction <= move_direction_next;
      center_count   <= center_count_next;
    end
  end

endmodule

/* rtl/core/pan_tilt_limit_scan_controller.sv */
// ----------------------------------------------------------------------------
// pan_tilt_limit_scan_controller
// Pan/tilt stepper controller with homing, manual moves and limit scanning.
// ----------------------------------------------------------------------------
// Takes one request (command or step tick) per clock while item_stall is low
// and returns one result per request. A request lands in an input register,
// is decided by the motion logic and written to the result register, which
// sets result_valid; sustained rate one request per cycle while result_stall
// is low. After reset the block homes pan, then tilt, then steps tilt to
// center; any defined command aborts that sequence. The user must write
// registers only while no request is in flight; the block does not check it.
module pan_tilt_limit_scan_controller
  import ptlsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  result_t result_next;
  logic    load_result;
  logic    accept;

  ptlsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptlsc_motion u_motion (
    .clk     (clk),
    .rst     (rst),
    .advance (load_result),
    .item    (item_q),
    .cfg     (cfg),
    .result  (result_next)
  );

  // Pipeline flow control
  assign load_result = item_q_valid && (!result_valid || !result_stall);
  assign item_stall  = item_q_valid && !load_result;
  assign accept      = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_q <= item;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) result <= result_next;
  end

endmodule
